FILE: rtl/cdtdn_pkg.sv
// shared types, constants and month tables for the civil date to day number block
package cdtdn_pkg;

    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DN_W    = 25;
    localparam int DOY_W   = 9;
    localparam int YOE_W   = 9;
    localparam int DOE_W   = 18;
    localparam int REM_W   = 5;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DOE_W-1:0] ERA_DAYS    = 18'd146097;
    localparam logic [DN_W-1:0]  EPOCH_SHIFT = 25'd719468;
    localparam logic [DOE_W-1:0] YEAR_DAYS   = 18'd365;
    localparam logic [REM_W-1:0] CENT_QUADS  = 5'd25;

    typedef struct packed {
        logic             ok_base;
        logic             feb29;
        logic [DOY_W-1:0] doy;
    } date_chk_t;

    // month length outside leap years, zero for codes that are no month
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // first day of the month within a year that starts on march 1
    function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] s;
        case (m)
            4'd3:    s = 9'd0;
            4'd4:    s = 9'd31;
            4'd5:    s = 9'd61;
            4'd6:    s = 9'd92;
            4'd7:    s = 9'd122;
            4'd8:    s = 9'd153;
            4'd9:    s = 9'd184;
            4'd10:   s = 9'd214;
            4'd11:   s = 9'd245;
            4'd12:   s = 9'd275;
            4'd1:    s = 9'd306;
            4'd2:    s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/cdtdn_date_check.sv
// month and day range check and day of the march-based year
module cdtdn_date_check
    import cdtdn_pkg::*;
(
    input  logic [MONTH_W-1:0] month,
    input  logic [DAY_W-1:0]   day_of_month,
    output date_chk_t          chk
);

    logic month_ok;
    logic day_ok;

    assign month_ok = (month >= MONTH_JAN) && (month <= MONTH_DEC);
    assign day_ok   = (day_of_month != '0) && (day_of_month <= month_len(month));

    always_comb begin
        chk.ok_base = month_ok && day_ok;
        // feb 29 passes only once the leap test is known further down
        chk.feb29   = (month == MONTH_FEB) && (day_of_month == 5'd29);
        chk.doy     = month_start(month) + DOY_W'(day_of_month) - 9'd1;
    end

endmodule

FILE: rtl/civil_date_to_day_number.sv
// top level: pipelined proleptic gregorian date to day number converter
//
//  channel | ports                                     | direction
//  s_      | s_year, s_month, s_day_of_month           | in,  valid/ready
//  m_      | m_date_valid, m_day_number                | out, valid/ready
//
// six register stages: one date per cycle while m_ready holds.
// era split is yy>>>4 then a reciprocal multiply by 1/25 with one correction;
// era times 146097 has its own stage.
// each stage holds while the one after it is full and stalled, so bubbles close.
// aresetn clears the valid bits only.
module civil_date_to_day_number
    import cdtdn_pkg::*;
#(
    parameter int YEAR_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [YEAR_BITS-1:0] s_year,
    input  logic [MONTH_W-1:0]          s_month,
    input  logic [DAY_W-1:0]            s_day_of_month,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_date_valid,
    output logic signed [DN_W-1:0]      m_day_number
);

    localparam int YY_W  = YEAR_BITS + 1;
    localparam int UB    = YEAR_BITS - 4;
    localparam int QB    = UB - 4;
    localparam int ERA_W = UB + 1;
    localparam int PR_W  = UB + QB;
    localparam logic [QB-1:0] RECIP = QB'((2 ** UB) / 25);

    // stage enables, each stage loads when empty or when the next one loads
    logic en1, en2, en3, en4, en5, en_out;

    // ---------------- stage 1: checks, shifted year, magnitude for the divide
    date_chk_t chk;

    cdtdn_date_check u_check (
        .month        (s_month),
        .day_of_month (s_day_of_month),
        .chk          (chk)
    );

    logic signed [YY_W-1:0]   yy;
    logic signed [YY_W-5:0]   yy_div16;
    logic                     v1_reg, v1_next;
    date_chk_t                chk1_reg, chk1_next;
    logic                     neg1_reg, neg1_next;
    logic [UB-1:0]            mag1_reg, mag1_next;
    logic [3:0]               low1_reg, low1_next;

    always_comb begin
        yy        = YY_W'(s_year) - ((s_month <= MONTH_FEB) ? YY_W'(1) : YY_W'(0));
        yy_div16  = yy[YY_W-1:4];
        v1_next   = en1 ? s_valid : v1_reg;
        chk1_next = chk;
        neg1_next = yy[YY_W-1];
        // floor of a negative quotient comes from the complement of the magnitude
        mag1_next = yy[YY_W-1] ? ~yy_div16[UB-1:0] : yy_div16[UB-1:0];
        low1_next = yy[3:0];
    end

    // ---------------- stage 2: reciprocal product
    logic            v2_reg, v2_next;
    date_chk_t       chk2_reg;
    logic            neg2_reg;
    logic [UB-1:0]   mag2_reg;
    logic [3:0]      low2_reg;
    logic [PR_W-1:0] prod2_reg, prod2_next;

    always_comb begin
        v2_next    = en2 ? v1_reg : v2_reg;
        prod2_next = PR_W'(mag1_reg) * PR_W'(RECIP);
    end

    // ---------------- stage 3: quotient correction
    logic [QB-1:0]    q_est;
    logic [UB-1:0]    rem_full;
    logic [5:0]       rem_est;
    logic             rem_big;
    logic             v3_reg, v3_next;
    date_chk_t        chk3_reg;
    logic             neg3_reg;
    logic [3:0]       low3_reg;
    logic [QB-1:0]    q3_reg, q3_next;
    logic [REM_W-1:0] rem3_reg, rem3_next;

    always_comb begin
        q_est     = prod2_reg[PR_W-1:UB];
        rem_full  = mag2_reg - UB'(q_est) * UB'(CENT_QUADS);
        rem_est   = rem_full[5:0];
        rem_big   = rem_est >= 6'(CENT_QUADS);
        v3_next   = en3 ? v2_reg : v3_reg;
        q3_next   = rem_big ? q_est + QB'(1) : q_est;
        rem3_next = rem_big ? REM_W'(rem_est - 6'(CENT_QUADS)) : rem_est[REM_W-1:0];
    end

    // ---------------- stage 4: era, year of era, leap test, day of era
    logic [REM_W-1:0]        rt;
    logic [YOE_W-1:0]        yoe;
    logic [1:0]              cents;
    logic                    leap;
    logic                    v4_reg, v4_next;
    logic                    ok4_reg, ok4_next;
    logic signed [ERA_W-1:0] era4_reg, era4_next;
    logic [DOE_W-1:0]        doe4_reg, doe4_next;

    always_comb begin
        rt    = neg3_reg ? (CENT_QUADS - 5'd1 - rem3_reg) : rem3_reg;
        yoe   = {rt, low3_reg};
        cents = 2'((yoe >= 9'd100) ? 1 : 0) + 2'((yoe >= 9'd200) ? 1 : 0)
              + 2'((yoe >= 9'd300) ? 1 : 0);
        // a february date sits in the year before, so the leap year is yoe + 1
        leap  = (yoe[1:0] == 2'b11) && (yoe != 9'd99) && (yoe != 9'd199) && (yoe != 9'd299);
        v4_next   = en4 ? v3_reg : v4_reg;
        ok4_next  = chk3_reg.ok_base || (chk3_reg.feb29 && leap);
        era4_next = neg3_reg ? ~ERA_W'(q3_reg) : ERA_W'(q3_reg);
        doe4_next = DOE_W'(yoe) * YEAR_DAYS + DOE_W'(yoe[YOE_W-1:2]) - DOE_W'(cents)
                  + DOE_W'(chk3_reg.doy);
    end

    // ---------------- stage 5: era days
    logic                  v5_reg, v5_next;
    logic                  ok5_reg;
    logic [DOE_W-1:0]      doe5_reg;
    logic [DN_W-1:0]       era_ext;
    logic [DN_W-1:0]       eday5_reg, eday5_next;

    always_comb begin
        era_ext    = DN_W'(era4_reg);
        v5_next    = en5 ? v4_reg : v5_reg;
        eday5_next = era_ext * DN_W'(ERA_DAYS);
    end

    // ---------------- output stage
    logic                   m_valid_reg, m_valid_next;
    logic                   m_date_valid_reg, m_date_valid_next;
    logic signed [DN_W-1:0] m_day_number_reg, m_day_number_next;

    always_comb begin
        m_valid_next      = en_out ? v5_reg : m_valid_reg;
        m_date_valid_next = ok5_reg;
        m_day_number_next = ok5_reg ? (eday5_reg + DN_W'(doe5_reg) - EPOCH_SHIFT) : '0;
    end

    assign m_valid      = m_valid_reg;
    assign m_date_valid = m_date_valid_reg;
    assign m_day_number = m_day_number_reg;

    // ---------------- stall chain
    assign en_out  = !m_valid || m_ready;
    assign en5     = !v5_reg || en_out;
    assign en4     = !v4_reg || en5;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    // ---------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            v3_reg      <= v3_next;
            v4_reg      <= v4_next;
            v5_reg      <= v5_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            chk1_reg <= chk1_next;
            neg1_reg <= neg1_next;
            mag1_reg <= mag1_next;
            low1_reg <= low1_next;
        end
        if (en2) begin
            chk2_reg  <= chk1_reg;
            neg2_reg  <= neg1_reg;
            mag2_reg  <= mag1_reg;
            low2_reg  <= low1_reg;
            prod2_reg <= prod2_next;
        end
        if (en3) begin
            chk3_reg <= chk2_reg;
            neg3_reg <= neg2_reg;
            low3_reg <= low2_reg;
            q3_reg   <= q3_next;
            rem3_reg <= rem3_next;
        end
        if (en4) begin
            ok4_reg  <= ok4_next;
            era4_reg <= era4_next;
            doe4_reg <= doe4_next;
        end
        if (en5) begin
            ok5_reg   <= ok4_reg;
            doe5_reg  <= doe4_reg;
            eday5_reg <= eday5_next;
        end
        if (en_out) begin
            m_date_valid_reg <= m_date_valid_next;
            m_day_number_reg <= m_day_number_next;
        end
    end

endmodule
